@@ rtl/core/sfrf_pkg.sv @@
// ---------------------------------------------------------------------------
// sfrf_pkg
// Shared types and constants for the stereo frame ring FIFO.
// ---------------------------------------------------------------------------
package sfrf_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned FRAME_W  = 2 * SAMPLE_W;
  localparam int unsigned FREE_W   = LEN_W + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } sfrf_op_e;

  typedef struct packed {
    sfrf_op_e              op;
    logic                  first_of_block;
    logic [LEN_W-1:0]      block_len;
    logic [SAMPLE_W-1:0]   left_in;
    logic [SAMPLE_W-1:0]   right_in;
  } sfrf_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   left_out;
    logic [SAMPLE_W-1:0]   right_out;
    logic                  underrun;
    logic                  dropped;
    logic                  was_read;
  } sfrf_out_t;

  typedef struct packed {
    logic underrun;
    logic dropped;
    logic was_read;
    logic hit;
  } sfrf_flags_t;

endpackage

@@ rtl/core/sfrf_store.sv @@
// ---------------------------------------------------------------------------
// sfrf_store
// Frame store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sfrf_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [sfrf_pkg::FRAME_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [sfrf_pkg::FRAME_W-1:0] rdata_o
);
  import sfrf_pkg::*;

  logic [FRAME_W-1:0] mem_q [DEPTH];
  logic [FRAME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sfrf_ctrl.sv @@
// ---------------------------------------------------------------------------
// sfrf_ctrl
// Block admission, staging and publish logic, read pointer and result flags.
// ---------------------------------------------------------------------------
module sfrf_ctrl #(
  parameter int unsigned FIFO_FRAMES = 1024,
  parameter int unsigned AW          = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         adv_i,
  input  sfrf_pkg::sfrf_in_t           item_i,
  output logic                         we_o,
  output logic [AW-1:0]                waddr_o,
  output logic                         re_o,
  output logic [AW-1:0]                raddr_o,
  output sfrf_pkg::sfrf_flags_t        flags_o
);
  import sfrf_pkg::*;

  localparam int unsigned CW = AW + 1;

  logic              enable_q;
  logic [CW-1:0]     pub_q, pub_d;
  logic [CW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     staged_q, staged_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              adm_q, adm_d;
  sfrf_flags_t       flags_q, flags_d;

  logic [CW-1:0]     fill;
  logic [FREE_W-1:0] free_frames;
  logic              fits;

  assign fill        = pub_q - rd_q;
  assign free_frames = FREE_W'(FIFO_FRAMES) - FREE_W'(fill);
  assign fits        = free_frames >= {1'b0, item_i.block_len};

  always_comb begin
    pub_d    = pub_q;
    rd_d     = rd_q;
    staged_d = staged_q;
    left_d   = left_q;
    adm_d    = adm_q;
    flags_d  = flags_q;
    we_o     = 1'b0;
    waddr_o  = pub_q[AW-1:0];
    re_o     = 1'b0;
    raddr_o  = rd_q[AW-1:0];

    if (adv_i) begin
      flags_d = '0;
      if (item_i.op == OP_READ) begin
        flags_d.was_read = 1'b1;
        if (fill == '0) begin
          flags_d.underrun = 1'b1;
        end else begin
          flags_d.hit = 1'b1;
          re_o        = 1'b1;
          rd_d        = rd_q + CW'(1);
        end
      end else begin
        flags_d.dropped = 1'b1;
        if (enable_q) begin
          if (item_i.first_of_block) begin
            staged_d = '0;
            adm_d    = 1'b0;
            left_d   = '0;
            if (item_i.block_len != '0) begin
              adm_d  = fits;
              left_d = item_i.block_len - LEN_W'(1);
              if (fits) begin
                we_o            = 1'b1;
                waddr_o         = pub_q[AW-1:0];
                staged_d        = CW'(1);
                flags_d.dropped = 1'b0;
              end
              if (left_d == '0) begin
                if (fits) begin
                  pub_d = pub_q + staged_d;
                end
                staged_d = '0;
                adm_d    = 1'b0;
              end
            end
          end else if (left_q != '0) begin
            left_d = left_q - LEN_W'(1);
            if (adm_q) begin
              we_o            = 1'b1;
              waddr_o         = AW'(pub_q + staged_q);
              staged_d        = staged_q + CW'(1);
              flags_d.dropped = 1'b0;
            end
            if (left_d == '0) begin
              if (adm_q) begin
                pub_d = pub_q + staged_d;
              end
              staged_d = '0;
              adm_d    = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      pub_q    <= '0;
      rd_q     <= '0;
      staged_q <= '0;
      left_q   <= '0;
      adm_q    <= 1'b0;
      flags_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      pub_q    <= pub_d;
      rd_q     <= rd_d;
      staged_q <= staged_d;
      left_q   <= left_d;
      adm_q    <= adm_d;
      flags_q  <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

@@ rtl/core/stereo_frame_ring_fifo.sv @@
// ---------------------------------------------------------------------------
// stereo_frame_ring_fifo
// Ring FIFO of stereo frames with whole-block admission and block publish.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries write or read
//   transactions; output channel (out_valid_o/out_ready_i/out_data_o)
//   returns exactly one result per input transaction, in order.
//   cfg_we_i/cfg_wdata_i set the enable bit; write only while idle.
//   Path: a taken transaction is held in the input register, processed when
//   it advances, and its result is held in the result register.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the pointer update between the input and result registers sets it.
//   Reads see a block's frames only after its last frame has been written.
//   Reset clears pointers, block state and enable; store contents are
//   undefined but unpublished entries are never read, so no clearing pass.
//   When the receiver stalls, the result is held and one more transaction
//   can wait in the input register before in_ready_o falls.
// ---------------------------------------------------------------------------
module stereo_frame_ring_fifo #(
  parameter int unsigned FIFO_FRAMES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sfrf_pkg::sfrf_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfrf_pkg::sfrf_out_t  out_data_o
);
  import sfrf_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_FRAMES);

  logic               s1_q;
  logic               out_q;
  sfrf_in_t           item_q;
  logic               adv;
  logic               we;
  logic [AW-1:0]      waddr;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [FRAME_W-1:0] rdata;
  sfrf_flags_t        flags;

  assign adv        = s1_q && (!out_q || out_ready_i);
  assign in_ready_o = !s1_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= 1'b0;
      out_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_q <= in_valid_i;
      end
      if (adv) begin
        out_q <= 1'b1;
      end else if (out_ready_i) begin
        out_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  sfrf_ctrl #(
    .FIFO_FRAMES (FIFO_FRAMES),
    .AW          (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .item_i      (item_q),
    .we_o        (we),
    .waddr_o     (waddr),
    .re_o        (re),
    .raddr_o     (raddr),
    .flags_o     (flags)
  );

  sfrf_store #(
    .DEPTH (FIFO_FRAMES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({item_q.left_in, item_q.right_in}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o          = out_q;
  assign out_data_o.left_out  = flags.hit ? rdata[FRAME_W-1:SAMPLE_W] : '0;
  assign out_data_o.right_out = flags.hit ? rdata[SAMPLE_W-1:0] : '0;
  assign out_data_o.underrun  = flags.underrun;
  assign out_data_o.dropped   = flags.dropped;
  assign out_data_o.was_read  = flags.was_read;

  a_ready_low_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_q && out_q && !out_ready_i)
  ) else $error("input stalled without a full pipeline");

  a_adv_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_q
  ) else $error("processed transaction produced no result");

  a_read_not_dropped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.was_read |-> !out_data_o.dropped
  ) else $error("read result flagged as dropped");

  a_underrun_no_hit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.underrun |-> (out_data_o.was_read && !flags.hit)
  ) else $error("underrun result with store data");

endmodule
